@@ sv/tfp_pkg.sv @@
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants for the TFTP packet field parser
// Parse phases, field tags, per-byte input item, result item and the
// parser state record.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Parse phase of the current packet
    typedef enum logic [3:0] {
        PH_OPC_HI    = 4'd0,
        PH_OPC_LO    = 4'd1,
        PH_FNAME     = 4'd2,
        PH_MODE      = 4'd3,
        PH_NUM_HI    = 4'd4,
        PH_NUM_LO    = 4'd5,
        PH_PAYLOAD   = 4'd6,
        PH_ERRMSG    = 4'd7,
        PH_OPT_START = 4'd8,
        PH_OPTNAME   = 4'd9,
        PH_OPTVAL    = 4'd10,
        PH_IGNORE    = 4'd11
    } t_phase;

    // Field tag given to each byte
    typedef enum logic [3:0] {
        K_OPCODE  = 4'd0,
        K_FNAME   = 4'd1,
        K_MODE    = 4'd2,
        K_BLOCK   = 4'd3,
        K_PAYLOAD = 4'd4,
        K_ERRCODE = 4'd5,
        K_ERRMSG  = 4'd6,
        K_OPTNAME = 4'd7,
        K_OPTVAL  = 4'd8,
        K_TERM    = 4'd9,
        K_IGNORED = 4'd10
    } t_kind;

    // TFTP opcodes
    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    // Smallest tail that still holds an option pair
    localparam logic [16:0] OPT_MIN_TAIL = 17'd4;
    localparam logic [15:0] POS_MAX      = 16'hffff;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [15:0] packet_length;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  data_byte;
        t_kind       field_kind;
        logic [3:0]  option_index;
        logic        packet_end;
        logic        malformed;
        logic [2:0]  opcode_value;
        logic [15:0] number_value;
        logic        number_valid;
    } t_res;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] pos;
        logic [15:0] opcode;
        logic [15:0] number;
        logic [3:0]  opt_cnt;
        logic        bad;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:   PH_OPC_HI,
        pos:     16'd0,
        opcode:  16'd0,
        number:  16'd0,
        opt_cnt: 4'd0,
        bad:     1'b0
    };

endpackage

@@ sv/tftp_packet_field_parser.sv @@
// ----------------------------------------------------------------------------
// tftp_packet_field_parser: tags each byte of a TFTP packet with its field
// Bytes enter on the slave stream and leave, one result per byte, on the
// master stream with field tag, option number, opcode and block number or error code.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one packet byte per item; tdata carries the byte and the
//   packet length, tlast marks the final byte of the packet.
//   Master stream: one result per byte; tuser carries the field tag, tlast
//   repeats the input's last-byte mark, and malformed is final on that item.
//   Path: an accepted input item is held in the input register, and its
//   result is then written to the result register for the master side.
//   Throughput: one item per cycle while the master side does not hold
//   tready low; the parse state is one register holding the state record,
//   updated by the logic between the two registers.
//   Reset: synchronous, active low; empties both registers and returns the
//   parser to the start of a packet. The parser also returns there by
//   itself after every byte marked tlast.
//   Stall: while the master side holds tready low the result stays put and
//   the input register can still take one more item; tready on the slave
//   side drops only when both registers are full.
// ----------------------------------------------------------------------------
module tftp_packet_field_parser #(
    parameter int MAX_OPTIONS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] byte_value, [23:8] packet_length
    input  logic        i_s_axis_tlast,  // last_byte
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [7:0] data_byte, [11:8] option_index,
                                         // [12] malformed, [15:13] opcode_value,
                                         // [31:16] number_value, [32] number_valid,
                                         // [39:33] zero
    output logic [3:0]  o_m_axis_tuser,  // [3:0] field_kind
    output logic        o_m_axis_tlast   // packet_end
);

    // Option index saturates at the smaller of MAX_OPTIONS and 15
    localparam logic [3:0] OPT_CAP = (MAX_OPTIONS > 15) ? 4'd15 : 4'(MAX_OPTIONS);

    logic            r_in_valid;
    tfp_pkg::t_in    r_in;
    logic            r_out_valid;
    tfp_pkg::t_res   r_out;
    tfp_pkg::t_state r_st;
    tfp_pkg::t_state n_st;
    tfp_pkg::t_res   n_res;
    logic            w_adv;
    logic            w_in_acc;
    logic            w_step;

    assign w_adv    = !r_out_valid || i_m_axis_tready;
    assign w_step   = w_adv && r_in_valid;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || w_adv;

    // Parse logic
    tfp_step #(
        .OPT_CAP (OPT_CAP)
    ) u_step (
        .i_state (r_st),
        .i_item  (r_in),
        .o_state (n_st),
        .o_res   (n_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.byte_value    <= i_s_axis_tdata[7:0];
            r_in.packet_length <= i_s_axis_tdata[23:8];
            r_in.last_byte     <= i_s_axis_tlast;
        end
    end

    // Parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_st        <= tfp_pkg::ST_RESET;
        end else begin
            if (w_adv) r_out_valid <= r_in_valid;
            if (w_step) r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) r_out <= n_res;
    end

    // Master stream packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.field_kind;
    assign o_m_axis_tlast  = r_out.packet_end;
    assign o_m_axis_tdata  = {7'd0, r_out.number_valid, r_out.number_value,
                              r_out.opcode_value, r_out.malformed,
                              r_out.option_index, r_out.data_byte};

    // Checks
    a_opcode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:13] <= 3'd6))
        else $error("opcode_value out of range");

    a_num_valid_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[32]) |->
        (o_m_axis_tdata[15:13] >= 3'd3 && o_m_axis_tdata[15:13] <= 3'd5))
        else $error("number_valid without a numbered opcode");

    a_opt_idx_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[11:8] != 4'd0) |->
        (o_m_axis_tuser == tfp_pkg::K_OPTNAME || o_m_axis_tuser == tfp_pkg::K_OPTVAL ||
         o_m_axis_tuser == tfp_pkg::K_TERM))
        else $error("option index outside an option");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.last_byte) |=> (r_st.phase == tfp_pkg::PH_OPC_HI &&
                                         r_st.pos == 16'd0))
        else $error("parser not back at packet start after last byte");

endmodule

@@ sv/tfp_step.sv @@
// ----------------------------------------------------------------------------
// tfp_step: per-byte parse logic
// From the current parser state and one input item, computes the next
// parser state and the tagged result item. Purely combinational.
// ----------------------------------------------------------------------------
module tfp_step #(
    parameter logic [3:0] OPT_CAP = 4'd15
) (
    input  tfp_pkg::t_state i_state,
    input  tfp_pkg::t_in    i_item,
    output tfp_pkg::t_state o_state,
    output tfp_pkg::t_res   o_res
);

    tfp_pkg::t_phase eff_phase;
    tfp_pkg::t_state upd;
    logic            is_null;
    logic            is_num_op;
    logic            op_valid;

    assign is_null = (i_item.byte_value == 8'd0);

    // Resolve the option-start phase against the bytes left
    always_comb begin
        eff_phase = i_state.phase;
        if (i_state.phase == tfp_pkg::PH_OPT_START) begin
            if ({1'b0, i_item.packet_length} >= ({1'b0, i_state.pos} + tfp_pkg::OPT_MIN_TAIL))
            begin
                eff_phase = tfp_pkg::PH_OPTNAME;
            end else begin
                eff_phase = tfp_pkg::PH_IGNORE;
            end
        end
    end

    // Next state
    always_comb begin
        upd = i_state;
        case (eff_phase)
            tfp_pkg::PH_OPC_HI: begin
                upd.opcode = {i_item.byte_value, 8'd0};
                upd.phase  = tfp_pkg::PH_OPC_LO;
                if (i_item.last_byte) upd.bad = 1'b1;
            end
            tfp_pkg::PH_OPC_LO: begin
                upd.opcode = {i_state.opcode[15:8], i_item.byte_value};
                if (upd.opcode == 16'd0 || upd.opcode > tfp_pkg::OP_OACK) begin
                    upd.bad   = 1'b1;
                    upd.phase = tfp_pkg::PH_IGNORE;
                end else if (upd.opcode == tfp_pkg::OP_RRQ ||
                             upd.opcode == tfp_pkg::OP_WRQ) begin
                    upd.phase = tfp_pkg::PH_FNAME;
                end else if (upd.opcode == tfp_pkg::OP_OACK) begin
                    upd.phase = tfp_pkg::PH_OPT_START;
                end else begin
                    upd.phase = tfp_pkg::PH_NUM_HI;
                    if (i_item.last_byte) upd.bad = 1'b1;
                end
            end
            tfp_pkg::PH_FNAME: begin
                if (is_null) upd.phase = tfp_pkg::PH_MODE;
            end
            tfp_pkg::PH_MODE: begin
                if (is_null) upd.phase = tfp_pkg::PH_OPT_START;
            end
            tfp_pkg::PH_NUM_HI: begin
                upd.number = {i_item.byte_value, 8'd0};
                upd.phase  = tfp_pkg::PH_NUM_LO;
                if (i_item.last_byte) upd.bad = 1'b1;
            end
            tfp_pkg::PH_NUM_LO: begin
                upd.number = {i_state.number[15:8], i_item.byte_value};
                if (i_state.opcode == tfp_pkg::OP_DATA) begin
                    upd.phase = tfp_pkg::PH_PAYLOAD;
                end else if (i_state.opcode == tfp_pkg::OP_ERROR) begin
                    upd.phase = tfp_pkg::PH_ERRMSG;
                end else begin
                    upd.phase = tfp_pkg::PH_IGNORE;
                end
            end
            tfp_pkg::PH_PAYLOAD: begin
                upd.phase = tfp_pkg::PH_PAYLOAD;
            end
            tfp_pkg::PH_ERRMSG: begin
                if (is_null) upd.phase = tfp_pkg::PH_IGNORE;
            end
            tfp_pkg::PH_OPTNAME: begin
                upd.phase = is_null ? tfp_pkg::PH_OPTVAL : tfp_pkg::PH_OPTNAME;
            end
            tfp_pkg::PH_OPTVAL: begin
                if (is_null) begin
                    upd.phase = tfp_pkg::PH_OPT_START;
                    if (i_state.opt_cnt < OPT_CAP) upd.opt_cnt = i_state.opt_cnt + 4'd1;
                end
            end
            default: begin
                upd.phase = tfp_pkg::PH_IGNORE;
            end
        endcase

        // Position counter saturates
        if (i_state.pos != tfp_pkg::POS_MAX) upd.pos = i_state.pos + 16'd1;
    end

    // Packet end returns to the reset state
    assign o_state = i_item.last_byte ? tfp_pkg::ST_RESET : upd;

    assign op_valid  = (upd.opcode >= tfp_pkg::OP_RRQ) && (upd.opcode <= tfp_pkg::OP_OACK);
    assign is_num_op = (upd.opcode >= tfp_pkg::OP_DATA) && (upd.opcode <= tfp_pkg::OP_ERROR);

    // Result item
    always_comb begin
        o_res              = '0;
        o_res.data_byte    = i_item.byte_value;
        o_res.packet_end   = i_item.last_byte;
        o_res.malformed    = upd.bad;
        o_res.field_kind   = tfp_pkg::K_IGNORED;
        o_res.option_index = 4'd0;
        case (eff_phase)
            tfp_pkg::PH_OPC_HI, tfp_pkg::PH_OPC_LO: begin
                o_res.field_kind = tfp_pkg::K_OPCODE;
            end
            tfp_pkg::PH_FNAME: begin
                o_res.field_kind = is_null ? tfp_pkg::K_TERM : tfp_pkg::K_FNAME;
            end
            tfp_pkg::PH_MODE: begin
                o_res.field_kind = is_null ? tfp_pkg::K_TERM : tfp_pkg::K_MODE;
            end
            tfp_pkg::PH_NUM_HI, tfp_pkg::PH_NUM_LO: begin
                o_res.field_kind = (i_state.opcode == tfp_pkg::OP_ERROR) ?
                                   tfp_pkg::K_ERRCODE : tfp_pkg::K_BLOCK;
            end
            tfp_pkg::PH_PAYLOAD: begin
                o_res.field_kind = tfp_pkg::K_PAYLOAD;
            end
            tfp_pkg::PH_ERRMSG: begin
                o_res.field_kind = is_null ? tfp_pkg::K_TERM : tfp_pkg::K_ERRMSG;
            end
            tfp_pkg::PH_OPTNAME: begin
                o_res.field_kind   = is_null ? tfp_pkg::K_TERM : tfp_pkg::K_OPTNAME;
                o_res.option_index = i_state.opt_cnt;
            end
            tfp_pkg::PH_OPTVAL: begin
                o_res.field_kind   = is_null ? tfp_pkg::K_TERM : tfp_pkg::K_OPTVAL;
                o_res.option_index = i_state.opt_cnt;
            end
            default: begin
                o_res.field_kind = tfp_pkg::K_IGNORED;
            end
        endcase

        // Opcode known from the second byte on
        if (i_state.pos != 16'd0 && op_valid) o_res.opcode_value = upd.opcode[2:0];

        // Block number / error code
        if (is_num_op && i_state.pos >= 16'd2) begin
            o_res.number_value = upd.number;
            if (upd.phase == tfp_pkg::PH_PAYLOAD || upd.phase == tfp_pkg::PH_ERRMSG ||
                upd.phase == tfp_pkg::PH_IGNORE) begin
                o_res.number_valid = 1'b1;
            end
        end
    end

endmodule
